// ===== rtl/gbs_pkg.sv =====
`timescale 1ns / 1ps

package gbs_pkg;

    localparam int IDX_W            = 19;
    localparam int PIX_W            = 8;
    localparam int SUM_W            = 16;
    localparam int SQ_W             = 24;
    localparam int FC_W             = 9;
    localparam int N_W              = 8;
    localparam int WEIGHT_W         = 16;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 16;

    localparam int PIXEL_COUNT      = 2 ** IDX_W;
    localparam int MAX_TRAIN_FRAMES = 255;
    localparam int DIV_STAGES       = SUM_W;

    localparam logic [N_W-1:0]      TRAIN_FRAMES_RESET = 8'd200;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET       = 16'd256;

    localparam logic [PIX_W-1:0] FG_ON  = 8'd255;
    localparam logic [PIX_W-1:0] FG_OFF = 8'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRAIN_FRAMES     = 2'd0,
        CFG_THRESHOLD_WEIGHT = 2'd1
    } cfg_reg_t;

endpackage

// ===== rtl/gbs_if.sv =====
`timescale 1ns / 1ps

interface gbs_pixel_if
    import gbs_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] pixel_index;
    logic [PIX_W-1:0] pixel_value;
    logic             frame_last;

    modport source (output valid, output pixel_index, output pixel_value,
                    output frame_last, input ready);
    modport sink   (input valid, input pixel_index, input pixel_value,
                    input frame_last, output ready);
endinterface

interface gbs_result_if
    import gbs_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] out_index;
    logic [PIX_W-1:0] foreground;
    logic             out_frame_last;

    modport source (output valid, output out_index, output foreground,
                    output out_frame_last, input ready);
    modport sink   (input valid, input out_index, input foreground,
                    input out_frame_last, output ready);
endinterface

// ===== rtl/gaussian_background_subtractor_unit.sv =====
`timescale 1ns / 1ps
// A classified pixel passes s1, the divider stages, sa, sb, sc, sd and the result
// queue. Throughput: one pixel per cycle while the queue has room or results.ready
// is high; the store is read per accepted pixel and written back per training
// pixel via one synchronous port pair with write forwarding. Reset: after rst_n
// rises a pass zeroes all 524288 entries, one per cycle, with pixels.ready low.

module gaussian_background_subtractor_unit
    import gbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    gbs_pixel_if.sink             pixels,
    gbs_result_if.source          results
);

    typedef struct packed {
        logic [SQ_W-1:0]  sq;
        logic [SUM_W-1:0] sum;
    } mem_word_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             last;
    } tag_t;

    typedef struct packed {
        logic             train;
        logic [PIX_W-1:0] pix;
        tag_t             tag;
    } s1_t;

    typedef struct packed {
        logic [N_W-1:0]   rem;
        logic [SUM_W-1:0] quo;
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  sq;
        logic [PIX_W-1:0] pix;
        tag_t             tag;
    } div_t;

    typedef struct packed {
        logic [2*SUM_W-1:0] ms;
        logic [2*SUM_W-1:0] mm;
        logic [SUM_W-1:0]   dif;
        logic [SQ_W-1:0]    sq;
        tag_t               tag;
    } sa_t;

    typedef struct packed {
        logic [2*SUM_W-1:0]     ms;
        logic [2*SUM_W+N_W-1:0] nmm;
        logic [SUM_W+N_W-1:0]   dn;
        logic [SQ_W-1:0]        sq;
        tag_t                   tag;
    } sb_t;

    typedef struct packed {
        logic [SQ_W-1:0]      varn;
        logic [SUM_W+N_W-1:0] dn;
        tag_t                 tag;
    } sc_t;

    typedef struct packed {
        logic [WEIGHT_W+SQ_W-1:0] lhs;
        logic [WEIGHT_W+SQ_W-1:0] rhs;
        tag_t                     tag;
    } sd_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [PIX_W-1:0] fg;
        logic             last;
    } res_t;

    // configuration and phase
    logic [N_W-1:0]      train_frames_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic [FC_W-1:0]     fc_reg;
    logic [FC_W-1:0]     fc_next;
    logic [N_W-1:0]      n_eff;
    logic [FC_W-1:0]     n_wide;
    logic                phase_train;
    logic                phase_cls;

    // clearing pass
    logic                init_done_reg;
    logic [IDX_W-1:0]    clr_addr_reg;

    // memory
    mem_word_t           model_mem [PIXEL_COUNT];
    mem_word_t           rd_data_reg;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    mem_word_t           mem_wdata;
    logic                fwd_valid_reg;
    logic [IDX_W-1:0]    fwd_addr_reg;
    mem_word_t           fwd_data_reg;
    mem_word_t           eff_word;
    mem_word_t           upd_word;
    logic [2*PIX_W-1:0]  pix_sq;

    // pipeline
    logic                adv;
    logic                in_accept;
    logic                s1_valid_reg;
    s1_t                 s1_reg;
    logic                s1_cls;
    logic [DIV_STAGES-1:0] dv_valid_reg;
    div_t                dv_reg [DIV_STAGES];
    div_t                dv_in [DIV_STAGES];
    div_t                dv_next [DIV_STAGES];
    logic                sa_valid_reg;
    logic                sb_valid_reg;
    logic                sc_valid_reg;
    logic                sd_valid_reg;
    sa_t                 sa_reg;
    sa_t                 sa_next;
    sb_t                 sb_reg;
    sb_t                 sb_next;
    sc_t                 sc_reg;
    sc_t                 sc_next;
    sd_t                 sd_reg;
    sd_t                 sd_next;
    logic [SUM_W-1:0]    pix_wide;
    logic signed [2*SUM_W+N_W+1:0] varn_s;

    // output queue
    res_t                fifo_reg [2];
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic [1:0]          cnt_reg;
    logic                push;
    logic                pop;
    res_t                push_data;

    // phase decode
    always_comb
    begin
        if (train_frames_reg == '0)
            n_eff = N_W'(1);
        else if (32'(train_frames_reg) > MAX_TRAIN_FRAMES)
            n_eff = N_W'(MAX_TRAIN_FRAMES);
        else
            n_eff = train_frames_reg;
        n_wide      = {1'b0, n_eff};
        phase_train = fc_reg < n_wide;
        phase_cls   = fc_reg > n_wide;
        if (in_accept && pixels.frame_last && fc_reg <= n_wide)
            fc_next = fc_reg + FC_W'(1);
        else
            fc_next = fc_reg;
    end

    assign adv          = (cnt_reg != 2'd2) || results.ready;
    assign pixels.ready = adv && init_done_reg;
    assign in_accept    = pixels.valid && pixels.ready;

    // read-modify-write at stage 1
    always_comb
    begin
        if (fwd_valid_reg && fwd_addr_reg == s1_reg.tag.idx)
            eff_word = fwd_data_reg;
        else
            eff_word = rd_data_reg;
        pix_sq       = {8'b0, s1_reg.pix} * {8'b0, s1_reg.pix};
        upd_word.sum = eff_word.sum + {8'b0, s1_reg.pix};
        upd_word.sq  = eff_word.sq + {8'b0, pix_sq};
        s1_cls       = s1_valid_reg && !s1_reg.train;
        if (!init_done_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = adv && s1_valid_reg && s1_reg.train;
            mem_waddr = s1_reg.tag.idx;
            mem_wdata = upd_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            model_mem[mem_waddr] <= mem_wdata;
        if (in_accept)
            rd_data_reg <= model_mem[pixels.pixel_index];
    end

    // mean = sum / n, one quotient bit per stage
    always_comb
    begin
        dv_in[0].rem = '0;
        dv_in[0].quo = '0;
        dv_in[0].sum = eff_word.sum;
        dv_in[0].sq  = eff_word.sq;
        dv_in[0].pix = s1_reg.pix;
        dv_in[0].tag = s1_reg.tag;
        for (int s = 1; s < DIV_STAGES; s++)
            dv_in[s] = dv_reg[s-1];
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            logic [N_W:0] trial;
            logic         ge;
            trial      = {dv_in[s].rem, dv_in[s].sum[SUM_W-1-s]};
            ge         = trial >= n_wide;
            dv_next[s] = dv_in[s];
            dv_next[s].rem = ge ? N_W'(trial - n_wide) : trial[N_W-1:0];
            dv_next[s].quo = {dv_in[s].quo[SUM_W-2:0], ge};
        end
    end

    // variance and threshold compare
    always_comb
    begin
        pix_wide    = {8'b0, dv_reg[DIV_STAGES-1].pix};
        sa_next.ms  = {16'b0, dv_reg[DIV_STAGES-1].quo} * {16'b0, dv_reg[DIV_STAGES-1].sum};
        sa_next.mm  = {16'b0, dv_reg[DIV_STAGES-1].quo} * {16'b0, dv_reg[DIV_STAGES-1].quo};
        sa_next.dif = (pix_wide >= dv_reg[DIV_STAGES-1].quo)
                    ? pix_wide - dv_reg[DIV_STAGES-1].quo
                    : dv_reg[DIV_STAGES-1].quo - pix_wide;
        sa_next.sq  = dv_reg[DIV_STAGES-1].sq;
        sa_next.tag = dv_reg[DIV_STAGES-1].tag;

        sb_next.ms  = sa_reg.ms;
        sb_next.nmm = {32'b0, n_eff} * {8'b0, sa_reg.mm};
        sb_next.dn  = {16'b0, n_eff} * {8'b0, sa_reg.dif};
        sb_next.sq  = sa_reg.sq;
        sb_next.tag = sa_reg.tag;

        varn_s = $signed({18'b0, sb_reg.sq}) - $signed({9'b0, sb_reg.ms, 1'b0})
               + $signed({2'b0, sb_reg.nmm});
        sc_next.varn = varn_s[2*SUM_W+N_W+1] ? '0 : varn_s[SQ_W-1:0];
        sc_next.dn   = sb_reg.dn;
        sc_next.tag  = sb_reg.tag;

        sd_next.lhs = {24'b0, weight_reg} * {16'b0, sc_reg.varn};
        sd_next.rhs = {8'b0, sc_reg.dn, 8'b0};
        sd_next.tag = sc_reg.tag;

        push_data.idx  = sd_reg.tag.idx;
        push_data.fg   = (sd_reg.lhs < sd_reg.rhs) ? FG_ON : FG_OFF;
        push_data.last = sd_reg.tag.last;
    end

    assign push = adv && sd_valid_reg;
    assign pop  = (cnt_reg != 2'd0) && results.ready;

    assign results.valid          = cnt_reg != 2'd0;
    assign results.out_index      = fifo_reg[rd_ptr_reg].idx;
    assign results.foreground     = fifo_reg[rd_ptr_reg].fg;
    assign results.out_frame_last = fifo_reg[rd_ptr_reg].last;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            train_frames_reg <= TRAIN_FRAMES_RESET;
            weight_reg       <= WEIGHT_RESET;
            fc_reg           <= '0;
            init_done_reg    <= 1'b0;
            clr_addr_reg     <= '0;
            fwd_valid_reg    <= 1'b0;
            s1_valid_reg     <= 1'b0;
            dv_valid_reg     <= '0;
            sa_valid_reg     <= 1'b0;
            sb_valid_reg     <= 1'b0;
            sc_valid_reg     <= 1'b0;
            sd_valid_reg     <= 1'b0;
            wr_ptr_reg       <= 1'b0;
            rd_ptr_reg       <= 1'b0;
            cnt_reg          <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_TRAIN_FRAMES:     train_frames_reg <= cfg_data[N_W-1:0];
                    CFG_THRESHOLD_WEIGHT: weight_reg       <= cfg_data[WEIGHT_W-1:0];
                    default: ;
                endcase
            end
            fc_reg <= fc_next;
            if (!init_done_reg)
            begin
                clr_addr_reg <= clr_addr_reg + IDX_W'(1);
                if (clr_addr_reg == IDX_W'(PIXEL_COUNT - 1))
                    init_done_reg <= 1'b1;
            end
            if (mem_we)
                fwd_valid_reg <= 1'b1;
            if (adv)
            begin
                s1_valid_reg <= in_accept && (phase_train || phase_cls);
                dv_valid_reg <= {dv_valid_reg[DIV_STAGES-2:0], s1_cls};
                sa_valid_reg <= dv_valid_reg[DIV_STAGES-1];
                sb_valid_reg <= sa_valid_reg;
                sc_valid_reg <= sb_valid_reg;
                sd_valid_reg <= sc_valid_reg;
            end
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            fwd_addr_reg <= mem_waddr;
            fwd_data_reg <= mem_wdata;
        end
        if (adv)
        begin
            if (in_accept)
            begin
                s1_reg.train    <= phase_train;
                s1_reg.pix      <= pixels.pixel_value;
                s1_reg.tag.idx  <= pixels.pixel_index;
                s1_reg.tag.last <= pixels.frame_last;
            end
            for (int s = 0; s < DIV_STAGES; s++)
                dv_reg[s] <= dv_next[s];
            sa_reg <= sa_next;
            sb_reg <= sb_next;
            sc_reg <= sc_next;
            sd_reg <= sd_next;
        end
        if (push)
            fifo_reg[wr_ptr_reg] <= push_data;
    end

    // checks
    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        !init_done_reg |-> !pixels.ready)
        else $error("pixel beat accepted during clearing pass");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2)
        else $error("result queue overflow");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2 && !results.ready) |-> !push)
        else $error("result pushed into full queue");

    a_init_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        init_done_reg |=> init_done_reg)
        else $error("clearing pass restarted");

    a_fc_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fc_reg != $past(fc_reg)) |-> (fc_reg == $past(fc_reg) + FC_W'(1)))
        else $error("frame counter jumped");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import gbs_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 7;
    localparam int CYCLE_LIMIT   = 4 * PIXEL_COUNT;
    localparam int SETTLE_CYCLES = 40;
    localparam int POOL_SIZE     = 6;
    localparam int PHASES        = 12;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [PIX_W-1:0] value;
        logic             last;
    } pixel_beat_t;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [PIX_W-1:0] foreground;
        logic             last;
    } label_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    gbs_pixel_if  pixels_if();
    gbs_result_if results_if();

    gaussian_background_subtractor_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pixels_if),
        .results   (results_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    logic [SUM_W-1:0]    bg_sum [int];
    logic [SQ_W-1:0]     bg_square_sum [int];
    logic [FC_W-1:0]     frame_count = '0;
    logic [N_W-1:0]      model_frames = TRAIN_FRAMES_RESET;
    logic [WEIGHT_W-1:0] model_weight = WEIGHT_RESET;

    pixel_beat_t pending_pixels [$];
    label_t      expected_labels [$];
    pixel_beat_t beat_on_bus;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count    = 0;
    int cycle_count   = 0;

    int pool_index [POOL_SIZE];
    int pool_base  [POOL_SIZE];
    int hot_index;

    int phase_frames [PHASES] = '{1, 4, 4, 2, 16, 40, 255, 200, 255, 0, 9, 128};
    int phase_weight [PHASES] = '{0, 65535, 384, 128, 200, 640, 300, 256,
                                  65535, 1, 1000, 96};

    function automatic void classify_pixel(pixel_beat_t beat);
        longint n, s, q, m, v, d, th;
        int     key;
        label_t lbl;
        key = int'(beat.index);
        n = (model_frames == '0) ? longint'(1) : longint'(model_frames);
        if (n > longint'(MAX_TRAIN_FRAMES))
            n = longint'(MAX_TRAIN_FRAMES);
        s = bg_sum.exists(key) ? longint'(bg_sum[key]) : longint'(0);
        q = bg_square_sum.exists(key) ? longint'(bg_square_sum[key]) : longint'(0);
        if (longint'(frame_count) < n)
        begin
            bg_sum[key] = SUM_W'(s + longint'(beat.value));
            bg_square_sum[key] = SQ_W'(q + longint'(beat.value) * longint'(beat.value));
        end
        else if (longint'(frame_count) > n)
        begin
            m = s / n;
            v = q - 2 * m * s + n * m * m;
            if (v < 0)
                v = 0;
            th = (longint'(model_weight) * v) / (256 * n);
            d = longint'(beat.value) - m;
            if (d < 0)
                d = -d;
            lbl.index = beat.index;
            lbl.foreground = (d > th) ? FG_ON : FG_OFF;
            lbl.last = beat.last;
            expected_labels.insert(expected_labels.size(), lbl);
        end
        if (beat.last && longint'(frame_count) <= n)
            frame_count = frame_count + 1'b1;
    endfunction

    // pixel driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pixels_if.valid <= 1'b0;
        end
        else
        begin
            if (pixels_if.valid && pixels_if.ready)
                classify_pixel(beat_on_bus);
            if (!pixels_if.valid || pixels_if.ready)
            begin
                if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    beat_on_bus = pending_pixels.pop_front();
                    pixels_if.valid       <= 1'b1;
                    pixels_if.pixel_index <= beat_on_bus.index;
                    pixels_if.pixel_value <= beat_on_bus.value;
                    pixels_if.frame_last  <= beat_on_bus.last;
                end
                else
                begin
                    pixels_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin : monitor
        label_t got;
        label_t want;
        if (!rst_n)
        begin
            results_if.ready <= 1'b0;
        end
        else
        begin
            if (results_if.valid && results_if.ready)
            begin
                got.index      = results_if.out_index;
                got.foreground = results_if.foreground;
                got.last       = results_if.out_frame_last;
                if (expected_labels.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("unexpected result beat: index %0d fg %0d last %0b",
                                 got.index, got.foreground, got.last);
                end
                else
                begin
                    want = expected_labels.pop_front();
                    if (got.index !== want.index || got.foreground !== want.foreground
                        || got.last !== want.last)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                            $display({"result mismatch: expected index %0d fg %0d last %0b,",
                                      " got index %0d fg %0d last %0b"},
                                     want.index, want.foreground, want.last,
                                     got.index, got.foreground, got.last);
                    end
                end
            end
            results_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL gaussian_background_subtractor_unit");
            $finish;
        end
    end

    function automatic logic [PIX_W-1:0] near(int base, int spread);
        int v;
        v = base + int'($urandom_range(2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[PIX_W-1:0];
    endfunction

    task automatic push_beat(int index, logic [PIX_W-1:0] value, logic last);
        pixel_beat_t b;
        b.index = index[IDX_W-1:0];
        b.value = value;
        b.last  = last;
        pending_pixels.insert(pending_pixels.size(), b);
    endtask

    task automatic wait_drained();
        while (pending_pixels.size() > 0 || pixels_if.valid || expected_labels.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= r;
        cfg_data  <= d;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (r == CFG_TRAIN_FRAMES)
            model_frames = d[N_W-1:0];
        else
            model_weight = d;
    endtask

    task automatic set_idling(int stage);
        case (stage)
            0:       begin send_idle_pct = 12; recv_idle_pct = 50; end
            1:       begin send_idle_pct = 50; recv_idle_pct = 12; end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        endcase
    endtask

    // hot pixel saturates at 255 so its sums wrap over a long training run
    task automatic queue_train_frame();
        int len, extra, k, p;
        len = $urandom_range(1, 2);
        extra = ($urandom_range(2) == 0) ? $urandom_range(1, 2) : 0;
        for (k = 0; k <= extra; k++)
            push_beat(hot_index, FG_ON, 1'b0);
        for (k = 0; k < len; k++)
        begin
            p = $urandom_range(POOL_SIZE - 1);
            push_beat(pool_index[p], near(pool_base[p], 6), k == len - 1);
        end
    endtask

    task automatic queue_build_frame();
        int len, k;
        len = $urandom_range(1, 4);
        for (k = 0; k < len; k++)
            push_beat($urandom_range(PIXEL_COUNT - 1), PIX_W'($urandom_range(255)),
                      k == len - 1);
    endtask

    task automatic queue_classify_frame();
        int len, k, p, sel;
        len = $urandom_range(4, 10);
        for (k = 0; k < len; k++)
        begin
            sel = $urandom_range(99);
            p = $urandom_range(POOL_SIZE - 1);
            if (sel < 70)
                push_beat(pool_index[p],
                          near(pool_base[p], ($urandom_range(3) == 0) ? 60 : 4), k == len - 1);
            else if (sel < 85)
                push_beat(hot_index, PIX_W'($urandom_range(255)), k == len - 1);
            else
                push_beat($urandom_range(PIXEL_COUNT - 1), PIX_W'($urandom_range(255)),
                          k == len - 1);
        end
    endtask

    task automatic run_phase(int frames, int weight, int stage);
        logic [CFG_DATA_W-1:0] d;
        int n, f;
        wait_drained();
        set_idling(stage);
        d = CFG_DATA_W'($urandom);
        d[N_W-1:0] = frames[N_W-1:0];
        write_reg(CFG_TRAIN_FRAMES, d);
        write_reg(CFG_THRESHOLD_WEIGHT, weight[WEIGHT_W-1:0]);
        n = (frames == 0) ? 1 : frames;
        for (f = int'(frame_count); f < n; f++)
            queue_train_frame();
        if (int'(frame_count) <= n)
            queue_build_frame();
        repeat (4) queue_classify_frame();
    endtask

    initial
    begin
        int p;
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_TRAIN_FRAMES;
        cfg_data  = '0;
        pixels_if.valid       = 1'b0;
        pixels_if.pixel_index = '0;
        pixels_if.pixel_value = '0;
        pixels_if.frame_last  = 1'b0;
        results_if.ready      = 1'b0;

        pool_index[0] = 0;
        pool_index[1] = PIXEL_COUNT - 1;
        for (p = 2; p < POOL_SIZE; p++)
            pool_index[p] = $urandom_range(1, PIXEL_COUNT - 2);
        for (p = 0; p < POOL_SIZE; p++)
            pool_base[p] = $urandom_range(255);
        hot_index = $urandom_range(1, PIXEL_COUNT - 2);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // zero frame count means one, repeated index drives variance negative,
        // unwritten entries classify against a zero model
        set_idling(0);
        write_reg(CFG_TRAIN_FRAMES, '0);
        write_reg(CFG_THRESHOLD_WEIGHT, WEIGHT_RESET);
        push_beat(0, 8'd0, 1'b0);
        push_beat(PIXEL_COUNT - 1, 8'd255, 1'b0);
        push_beat(5, 8'd255, 1'b0);
        push_beat(5, 8'd255, 1'b0);
        push_beat(5, 8'd1, 1'b1);
        push_beat(0, 8'd99, 1'b0);
        push_beat(5, 8'd3, 1'b1);
        push_beat(0, 8'd0, 1'b0);
        push_beat(0, 8'd1, 1'b0);
        push_beat(PIXEL_COUNT - 1, 8'd255, 1'b0);
        push_beat(PIXEL_COUNT - 1, 8'd0, 1'b0);
        push_beat(PIXEL_COUNT - 1, 8'd254, 1'b0);
        push_beat(5, 8'd170, 1'b0);
        push_beat(5, 8'd171, 1'b0);
        push_beat(5, 8'd0, 1'b0);
        push_beat(12345, 8'd0, 1'b0);
        push_beat(12345, 8'd1, 1'b1);

        for (p = 0; p < PHASES; p++)
            run_phase(phase_frames[p], phase_weight[p], p * 3 / PHASES);

        wait_drained();
        if (fail_count == 0)
            $display("PASS gaussian_background_subtractor_unit");
        else
            $display("FAIL gaussian_background_subtractor_unit");
        $finish;
    end

endmodule
